### src/mtfz_pkg.sv
// ---------------------------------------------------------------------------
// mtfz_pkg: shared types and constants of the zero-run encoder
// Field widths of the rank and symbol streams and the result item type.
// ---------------------------------------------------------------------------
package mtfz_pkg;

  localparam int RankW     = 8;
  localparam int SymW      = 9;
  localparam int OutDataW  = 16;

  // Terminator symbol value after reset.
  localparam logic [SymW-1:0] TermReset = 9'd257;

  // One result item as held in the output register.
  typedef struct packed {
    logic [SymW-1:0] symbol;
    logic            last_in_run;
  } out_item_t;

endpackage

### src/mtf_rank_zero_run_encoder_core.sv
// ---------------------------------------------------------------------------
// mtf_rank_zero_run_encoder_core: zero-run coder for move-to-front ranks
// Counts zero ranks and sends each run as bijective base-2 digits, then the
// rank plus one, and the terminator symbol at the end of a block.
//
// Channel   Dir  Payload
// s_axis    in   tdata[7:0] rank, tlast block_end
// m_axis    out  tdata[8:0] symbol (rest zero), tlast last_in_run
// cfg       in   cfg_wen, cfg_wdata[8:0] terminator_symbol
//
// A zero rank that does not end the block is counted and gives no item. Any
// other item gives the run digits, the rank plus one if nonzero, then the
// terminator at a block end; the run shifter sends one digit per cycle when
// the output is free. The input is not ready while an item is worked on.
// Output stalls hold the sequencer; one finished item waits in the output
// register. Reset clears the run count and sets the terminator to 257.
// ---------------------------------------------------------------------------
module mtf_rank_zero_run_encoder_core
  import mtfz_pkg::*;
#(
  parameter int MAX_RUN_DIGITS = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [RankW-1:0]    s_axis_tdata,   // [7:0] rank
  input  logic                s_axis_tlast,   // block_end
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [8:0] symbol, [15:9] zero
  output logic                m_axis_tlast,   // last_in_run
  input  logic                cfg_wen,
  input  logic [SymW-1:0]     cfg_wdata       // terminator_symbol
);

  localparam int RunW = MAX_RUN_DIGITS + 1;
  localparam logic [RunW-1:0] RunLimit = {{(RunW-1){1'b1}}, 1'b0};

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DIGITS = 2'd1;
  localparam logic [1:0] ST_RANK   = 2'd2;
  localparam logic [1:0] ST_TERM   = 2'd3;

  logic [1:0]      state;
  logic [1:0]      state_next;
  logic [RunW-1:0] run_len;
  logic [RunW-1:0] run_inc;
  logic [RunW-1:0] new_run;
  logic [RankW-1:0] rank_q;
  logic            last_q;
  logic [SymW-1:0] term_sym;
  logic            accept;
  logic            load;
  logic            shift;
  logic            digit;
  logic            digit_done;
  logic            push;
  out_item_t       push_item;
  logic            out_free;

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Saturating count of pending zeros.
  assign run_inc = (run_len < RunLimit) ? run_len + 1'b1 : run_len;
  assign new_run = (s_axis_tdata == '0) ? run_inc : run_len;
  assign load    = accept && ((s_axis_tdata != '0) || s_axis_tlast);

  // Run digit shifter, loaded with run length plus one.
  mtfz_digit_unit #(.W(RunW)) u_digits (
    .clk        (clk),
    .load       (load),
    .load_value (new_run + 1'b1),
    .shift      (shift),
    .digit      (digit),
    .done       (digit_done)
  );

  // Sequencer: digits, rank plus one if nonzero, terminator at block end.
  always_comb begin
    state_next = state;
    push       = 1'b0;
    shift      = 1'b0;
    push_item  = '{symbol: '0, last_in_run: 1'b0};
    case (state)
      ST_IDLE: begin
        if (load) begin
          state_next = ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        if (!digit_done) begin
          shift     = out_free;
          push      = out_free;
          push_item = '{symbol: {{(SymW-1){1'b0}}, digit}, last_in_run: 1'b0};
        end else begin
          state_next = (rank_q != '0) ? ST_RANK : ST_TERM;
        end
      end
      ST_RANK: begin
        push      = out_free;
        push_item = '{symbol: {1'b0, rank_q} + 1'b1, last_in_run: !last_q};
        if (out_free) begin
          state_next = last_q ? ST_TERM : ST_IDLE;
        end
      end
      ST_TERM: begin
        push      = out_free;
        push_item = '{symbol: term_sym, last_in_run: 1'b1};
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control state and run count.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      run_len <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        run_len <= load ? '0 : run_inc;
      end
    end
  end

  // Item fields kept for the later steps.
  always_ff @(posedge clk) begin
    if (accept) begin
      rank_q <= s_axis_tdata;
      last_q <= s_axis_tlast;
    end
  end

  // Terminator register.
  always_ff @(posedge clk) begin
    if (rst) begin
      term_sym <= TermReset;
    end else if (cfg_wen) begin
      term_sym <= cfg_wdata;
    end
  end

  // Output register.
  mtfz_out_reg u_out (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .push_item     (push_item),
    .free          (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // The run count never passes its saturation value.
  a_run_limit: assert property (@(posedge clk) disable iff (rst)
    run_len <= RunLimit)
    else $error("run count above saturation value");

  // A zero rank inside a block is only counted and leaves the block ready.
  a_zero_stays_idle: assert property (@(posedge clk) disable iff (rst)
    accept && (s_axis_tdata == '0) && !s_axis_tlast |=> s_axis_tready)
    else $error("zero rank did not return to ready");

  // A block end always leads to work and clears the run count.
  a_block_end_busy: assert property (@(posedge clk) disable iff (rst)
    accept && s_axis_tlast |=> !s_axis_tready && (run_len == '0))
    else $error("block end not processed");

  // Run digits are only 0 or 1 and never end an item's results.
  a_digit_value: assert property (@(posedge clk) disable iff (rst)
    push && (state == ST_DIGITS) |-> (push_item.symbol[SymW-1:1] == '0)
      && !push_item.last_in_run)
    else $error("bad run digit");

endmodule

### src/mtfz_digit_unit.sv
// ---------------------------------------------------------------------------
// mtfz_digit_unit: run digit shifter
// Holds run length plus one and hands out its bits below the leading one,
// least significant first, one per shift.
// ---------------------------------------------------------------------------
module mtfz_digit_unit #(
  parameter int W = 25
) (
  input  logic         clk,
  input  logic         load,
  input  logic [W-1:0] load_value,
  input  logic         shift,
  output logic         digit,
  output logic         done
);

  logic [W-1:0] value;

  // Load a new run, or drop the digit just sent.
  always_ff @(posedge clk) begin
    if (load) begin
      value <= load_value;
    end else if (shift) begin
      value <= {1'b0, value[W-1:1]};
    end
  end

  // Only the leading one is left once all digits are out.
  assign digit = value[0];
  assign done  = (value[W-1:1] == '0);

endmodule

### src/mtfz_out_reg.sv
// ---------------------------------------------------------------------------
// mtfz_out_reg: result output register
// Holds one result item on the master stream until it is taken.
// ---------------------------------------------------------------------------
module mtfz_out_reg
  import mtfz_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  out_item_t           push_item,
  output logic                free,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic                m_axis_tlast
);

  logic      valid;
  out_item_t item;

  assign free = !valid || m_axis_tready;

  // Valid flag of the held item.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (push) begin
      valid <= 1'b1;
    end else if (m_axis_tready) begin
      valid <= 1'b0;
    end
  end

  // Payload of the held item.
  always_ff @(posedge clk) begin
    if (push) begin
      item <= push_item;
    end
  end

  assign m_axis_tvalid = valid;
  assign m_axis_tdata  = {{(OutDataW-SymW){1'b0}}, item.symbol};
  assign m_axis_tlast  = item.last_in_run;

endmodule
